>>> hw/rtl/absc_pkg.sv
// ----------------------------------------------------------------------------
// absc_pkg
// Types, codes and helpers shared by the span compositor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package absc_pkg;

	localparam int MaxSide   = 256;
	localparam int AddrW     = 16;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 32;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_PIXEL = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		MODE_COPY = 2'd0,
		MODE_RGBA = 2'd1,
		MODE_MASK = 2'd2,
		MODE_TINT = 2'd3
	} blend_mode_t;

	typedef enum logic [2:0] {
		CFG_MODE   = 3'd0,
		CFG_WIDTH  = 3'd1,
		CFG_HEIGHT = 3'd2,
		CFG_COUNT  = 3'd3,
		CFG_STEP_U = 3'd4,
		CFG_STEP_V = 3'd5,
		CFG_FILL   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        texel_index;
		logic [7:0]         data_c0;
		logic [7:0]         data_c1;
		logic [7:0]         data_c2;
		logic [7:0]         data_c3;
		logic signed [31:0] u_start;
		logic signed [31:0] v_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_c0;
		logic [7:0] out_c1;
		logic [7:0] out_c2;
		logic [7:0] out_c3;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       write_texel;
		logic       start_span;
		logic       start_pixel;
		logic       rd_issue;
		logic [1:0] rd_sel;
		logic       horz;
		logic       vert;
		logic       blend;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	// round-to-nearest a*b/255
	function automatic logic [7:0] mul255(input logic [7:0] a, input logic [7:0] b);
		logic [16:0] x;
		begin
			x = {1'b0, {8'd0, a} * {8'd0, b}} + 17'd128;
			x = x + {8'd0, x[16:8]};
			mul255 = x[15:8];
		end
	endfunction

	function automatic logic [7:0] sat8(input logic [8:0] x);
		sat8 = x[8] ? 8'hFF : x[7:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/absc_ctrl.sv
// ----------------------------------------------------------------------------
// absc_ctrl
// Sequencer: takes transactions, walks the four texel reads and the
// interpolation and blend steps of a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module absc_ctrl import absc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_cmd,
	output logic            in_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_WAIT  = 6'b000100,
		ST_HORZ  = 6'b001000,
		ST_VERT  = 6'b010000,
		ST_BLEND = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.rd_sel      = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.write_texel = (in_cmd == CMD_WRITE);
					cmd.start_span  = (in_cmd == CMD_START);
					cmd.start_pixel = (in_cmd == CMD_PIXEL);
					if (in_cmd == CMD_PIXEL) state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				if (cnt_q == 2'd3) state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_HORZ;
			ST_HORZ: begin
				cmd.horz = 1'b1;
				state_d  = ST_VERT;
			end
			ST_VERT: begin
				cmd.vert = 1'b1;
				state_d  = ST_BLEND;
			end
			ST_BLEND: begin
				// hold until the output register can take the result
				if (!status.out_busy) begin
					cmd.blend = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) cnt_q <= cnt_q + 2'd1;
			else cnt_q <= '0;
		end
	end

`default_nettype wire
endmodule

>>> hw/rtl/absc_dp.sv
// ----------------------------------------------------------------------------
// absc_dp
// Datapath: configuration, texel store, span position, bilinear filter,
// compositing and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module absc_dp import absc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire in_item_t            in_data,
	input  wire dp_cmd_t             cmd,
	output dp_status_t               status,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_item_t                out_data
);

	logic [1:0]  mode_q;
	logic [8:0]  width_q, height_q;
	logic [2:0]  count_q;
	logic [31:0] step_u_q, step_v_q;
	logic [23:0] fill_q;

	logic [31:0] mem [0:(1<<AddrW)-1];
	logic [31:0] mem_rd_q;

	logic [31:0] u_pos_q, v_pos_q;
	logic [15:0] ui_q, vi_q, ud_q, vd_q;
	logic [7:0]  dst_q [0:3];

	logic        pend_s1, oob_s1;
	logic [1:0]  sel_s1;
	logic [31:0] tex_q [0:3];

	logic [7:0]  ab_q [0:3];
	logic [7:0]  cd_q [0:3];
	logic [7:0]  smp_q [0:3];
	logic        out_valid_q;
	out_item_t   out_q;

	logic [8:0]  w_eff, h_eff;
	logic [16:0] col, row;
	logic        oob;
	logic [AddrW:0] addr_full;
	logic [AddrW-1:0] addr;

	assign w_eff = (width_q > 9'(MaxSide)) ? 9'(MaxSide) : width_q;
	assign h_eff = (height_q > 9'(MaxSide)) ? 9'(MaxSide) : height_q;

	always_comb begin
		col       = {ui_q[15], ui_q} + {16'd0, cmd.rd_sel[0]};
		row       = {vi_q[15], vi_q} + {16'd0, cmd.rd_sel[1]};
		oob       = col[16] || row[16] || (col >= {8'd0, w_eff}) || (row >= {8'd0, h_eff});
		addr_full = row[7:0] * w_eff + {9'd0, col[7:0]};
		addr      = addr_full[AddrW-1:0];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_COPY;
			width_q  <= 9'd1;
			height_q <= 9'd1;
			count_q  <= 3'd4;
			step_u_q <= 32'h0001_0000;
			step_v_q <= '0;
			fill_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_WIDTH:  width_q  <= cfg_data[8:0];
				CFG_HEIGHT: height_q <= cfg_data[8:0];
				CFG_COUNT:  count_q  <= cfg_data[2:0];
				CFG_STEP_U: step_u_q <= cfg_data;
				CFG_STEP_V: step_v_q <= cfg_data;
				CFG_FILL:   fill_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// texel store
	always_ff @(posedge clk) begin
		if (cmd.write_texel)
			mem[in_data.texel_index] <= {in_data.data_c3, in_data.data_c2,
				in_data.data_c1, in_data.data_c0};
		mem_rd_q <= mem[addr];
	end

	// span position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_pos_q <= '0;
			v_pos_q <= '0;
		end else if (cmd.start_span) begin
			u_pos_q <= in_data.u_start;
			v_pos_q <= in_data.v_start;
		end else if (cmd.start_pixel) begin
			u_pos_q <= u_pos_q + step_u_q;
			v_pos_q <= v_pos_q + step_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_pixel) begin
			ui_q     <= u_pos_q[31:16];
			vi_q     <= v_pos_q[31:16];
			ud_q     <= u_pos_q[15:0];
			vd_q     <= v_pos_q[15:0];
			dst_q[0] <= in_data.data_c0;
			dst_q[1] <= in_data.data_c1;
			dst_q[2] <= in_data.data_c2;
			dst_q[3] <= in_data.data_c3;
		end
	end

	// neighbor capture, in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_s1 <= 1'b0;
		else pend_s1 <= cmd.rd_issue;
	end

	always_ff @(posedge clk) begin
		sel_s1 <= cmd.rd_sel;
		oob_s1 <= oob;
		if (pend_s1) tex_q[sel_s1] <= oob_s1 ? 32'd0 : mem_rd_q;
	end

	function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
		input logic [15:0] t);
		logic signed [8:0]  diff;
		logic signed [25:0] p;
		logic signed [9:0]  r;
		begin
			diff = $signed({1'b0, b}) - $signed({1'b0, a});
			p    = diff * $signed({1'b0, t});
			r    = $signed({2'b00, a}) + p[25:16];
			lerp = r[7:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (cmd.horz) begin
				ab_q[k] <= lerp(tex_q[0][8*k +: 8], tex_q[1][8*k +: 8], ud_q);
				cd_q[k] <= lerp(tex_q[2][8*k +: 8], tex_q[3][8*k +: 8], ud_q);
			end
			if (cmd.vert) smp_q[k] <= lerp(ab_q[k], cd_q[k], vd_q);
		end
	end

	// compositing
	out_item_t   res;
	logic [7:0]  inv;
	logic [7:0]  r [0:3];
	logic [7:0]  tint [1:3];
	logic [2:0]  n_eff;

	always_comb begin
		inv     = 8'd255 - smp_q[0];
		n_eff   = (count_q > 3'd4) ? 3'd4 : count_q;
		tint[1] = fill_q[23:16];
		tint[2] = fill_q[15:8];
		tint[3] = fill_q[7:0];
		for (int k = 0; k < 4; k++) r[k] = 8'd0;
		case (mode_q)
			MODE_COPY: begin
				for (int k = 0; k < 4; k++)
					r[k] = (3'(k) < n_eff) ? smp_q[k] : 8'd0;
			end
			MODE_RGBA: begin
				for (int k = 0; k < 4; k++)
					r[k] = sat8({1'b0, smp_q[k]} + {1'b0, mul255(dst_q[k], inv)});
			end
			default: begin
				r[0] = sat8({1'b0, smp_q[0]} + {1'b0, mul255(dst_q[0], inv)});
				if (mode_q == MODE_TINT)
					for (int k = 1; k < 4; k++)
						r[k] = sat8({1'b0, mul255(tint[k], smp_q[0])}
							+ {1'b0, mul255(dst_q[k], inv)});
			end
		endcase
		res = '{out_c0: r[0], out_c1: r[1], out_c2: r[2], out_c3: r[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.blend) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.blend) out_q <= res;
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

`default_nettype wire
endmodule

>>> hw/rtl/affine_bilinear_span_compositor_unit.sv
// A pixel transaction stalls the input until its result is registered:
// four neighbor reads through the single read port of the texel store,
// filter, blend and the return to idle; a stalled result holds the blend
// step. Writes, starts and unused commands leave the input free.
// Reset: asynchronous, active low; clears control, configuration and span
// position. The texel store is not cleared and must be written before use.
// ----------------------------------------------------------------------------
// affine_bilinear_span_compositor_unit
// Affine span bilinear texture sampler; copy, premultiplied over, mask, tint.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_bilinear_span_compositor_unit import absc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	// input transactions
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_item_t            in_data,
	// result transactions
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_item_t                out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer: accept a transaction when idle, then step the read,
	// filter and blend phases of a pixel.
	absc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: store, position walk, filter and compositing; the output
	// register lets the next transaction in while a result waits.
	absc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`default_nettype wire
endmodule

>>> hw/rtl/absc_checker.sv
// ----------------------------------------------------------------------------
// absc_checker
// Port-level checks for the span compositor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module absc_checker import absc_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_PIXEL |=> in_stall)
		else $error("pixel transaction did not occupy the unit");

	a_other_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd != CMD_PIXEL |=> !in_stall)
		else $error("non-pixel transaction stalled the input");

endmodule

bind affine_bilinear_span_compositor_unit absc_checker u_absc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

>>> dv/affine_bilinear_span_compositor_unit_test.sv
// ----------------------------------------------------------------------------
// affine_bilinear_span_compositor_unit_test
// Self-checking bench for the span compositor. It drives texel writes, span
// starts and pixel transactions with random gaps and output stalls. It also
// predicts every pixel from its own copy of the store, the position and the
// registers, and checks each result in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_bilinear_span_compositor_unit_test;
	import absc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;

	affine_bilinear_span_compositor_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// shadow of the block: texel store, span position, registers
	logic [31:0] texel_mem [0:65535];
	bit          texel_seen [0:65535];
	logic [31:0] pos_u, pos_v;
	logic [1:0]  mode_r;
	logic [8:0]  width_r, height_r;
	logic [2:0]  count_r;
	logic [31:0] step_u_r, step_v_r;
	logic [23:0] fill_r;

	out_item_t pending_pixels [$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        pixels_checked = 0;
	int        phases_run = 0;
	bit        no_gaps = 0;
	int        long_hold = 0;

	task automatic report(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// ---------------------------------------------------------------- predictor
	function automatic int eff_width();
		return (width_r > MaxSide) ? MaxSide : int'(width_r);
	endfunction

	function automatic int eff_height();
		return (height_r > MaxSide) ? MaxSide : int'(height_r);
	endfunction

	function automatic int texel_at(input int col, input int row, input int k);
		int idx;
		if (col < 0 || col >= eff_width() || row < 0 || row >= eff_height())
			return 0;
		idx = row * eff_width() + col;
		if (idx >= 65536)
			return 0;
		return int'((texel_mem[idx] >> (8 * k)) & 32'hFF);
	endfunction

	// floor toward minus infinity of the scaled product
	function automatic int lerp16(input int a, input int b, input int t);
		int p;
		p = (b - a) * t;
		if (p >= 0)
			return a + (p >>> 16);
		return a - ((-p + 65535) >>> 16);
	endfunction

	function automatic int sample_comp(input int k);
		int ui, vi, ud, vd, top, bot;
		ui = $signed(pos_u) >>> 16;
		vi = $signed(pos_v) >>> 16;
		ud = int'(pos_u[15:0]);
		vd = int'(pos_v[15:0]);
		top = lerp16(texel_at(ui, vi, k), texel_at(ui + 1, vi, k), ud);
		bot = lerp16(texel_at(ui, vi + 1, k), texel_at(ui + 1, vi + 1, k), ud);
		return lerp16(top, bot, vd);
	endfunction

	function automatic int scale255(input int a, input int b);
		int x;
		x = a * b + 128;
		x += x >>> 8;
		return x >>> 8;
	endfunction

	function automatic logic [7:0] clamp8(input int x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'hFF;
		return x[7:0];
	endfunction

	// composite one pixel at the current position, then advance the position
	function automatic out_item_t composite_pixel(input in_item_t it);
		logic [7:0] r [4];
		int dst [4];
		int src [4];
		int tint [3];
		int inv, n;
		out_item_t o;
		dst[0] = int'(it.data_c0);
		dst[1] = int'(it.data_c1);
		dst[2] = int'(it.data_c2);
		dst[3] = int'(it.data_c3);
		for (int k = 0; k < 4; k++)
			r[k] = 8'd0;
		case (blend_mode_t'(mode_r))
			MODE_COPY: begin
				n = (count_r > 4) ? 4 : int'(count_r);
				for (int k = 0; k < n; k++)
					r[k] = clamp8(sample_comp(k));
			end
			MODE_RGBA: begin
				for (int k = 0; k < 4; k++)
					src[k] = sample_comp(k);
				inv = 255 - src[0];
				for (int k = 0; k < 4; k++)
					r[k] = clamp8(src[k] + scale255(dst[k], inv));
			end
			default: begin
				src[0] = sample_comp(0);
				inv = 255 - src[0];
				r[0] = clamp8(src[0] + scale255(dst[0], inv));
				if (mode_r == MODE_TINT) begin
					tint[0] = int'(fill_r[23:16]);
					tint[1] = int'(fill_r[15:8]);
					tint[2] = int'(fill_r[7:0]);
					for (int k = 1; k < 4; k++)
						r[k] = clamp8(scale255(tint[k-1], src[0]) + scale255(dst[k], inv));
				end
			end
		endcase
		pos_u += step_u_r;
		pos_v += step_v_r;
		o.out_c0 = r[0];
		o.out_c1 = r[1];
		o.out_c2 = r[2];
		o.out_c3 = r[3];
		return o;
	endfunction

	function automatic void apply_item(input in_item_t it);
		case (cmd_code_t'(it.cmd))
			CMD_WRITE: begin
				texel_mem[it.texel_index] = {it.data_c3, it.data_c2, it.data_c1, it.data_c0};
				texel_seen[it.texel_index] = 1'b1;
			end
			CMD_START: begin
				pos_u = it.u_start;
				pos_v = it.v_start;
			end
			CMD_PIXEL: pending_pixels.push_back(composite_pixel(it));
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------ driving
	// Offer one transaction after a random gap; hold it until the block takes it.
	task automatic send_item(input in_item_t it);
		int gap;
		bit taken;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		apply_item(it);
		items_sent++;
	endtask

	// Drop valid once the stream pauses; the pending edge already passed.
	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every expected pixel, then let any write or start finish.
	task automatic drain();
		go_quiet();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Settle the block first so that no transaction is in flight during the write.
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_MODE:   mode_r   = value[1:0];
			CFG_WIDTH:  width_r  = value[8:0];
			CFG_HEIGHT: height_r = value[8:0];
			CFG_COUNT:  count_r  = value[2:0];
			CFG_STEP_U: step_u_r = value;
			CFG_STEP_V: step_v_r = value;
			CFG_FILL:   fill_r   = value[23:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [1:0] m, input logic [8:0] w, input logic [8:0] h,
			input logic [2:0] c, input logic [31:0] su, input logic [31:0] sv,
			input logic [23:0] f);
		write_reg(CFG_MODE, 32'(m));
		write_reg(CFG_WIDTH, 32'(w));
		write_reg(CFG_HEIGHT, 32'(h));
		write_reg(CFG_COUNT, 32'(c));
		write_reg(CFG_STEP_U, su);
		write_reg(CFG_STEP_V, sv);
		write_reg(CFG_FILL, 32'(f));
	endtask

	function automatic in_item_t rand_item(input cmd_code_t c);
		in_item_t it;
		it.cmd         = c;
		it.texel_index = 16'($urandom_range(0, 65535));
		it.data_c0     = 8'($urandom_range(0, 255));
		it.data_c1     = 8'($urandom_range(0, 255));
		it.data_c2     = 8'($urandom_range(0, 255));
		it.data_c3     = 8'($urandom_range(0, 255));
		it.u_start     = $urandom;
		it.v_start     = $urandom;
		return it;
	endfunction

	task automatic put_texel(input int idx);
		in_item_t it;
		it = rand_item(CMD_WRITE);
		it.texel_index = 16'(idx);
		send_item(it);
	endtask

	// Make every texel the sampler can reach valid; refresh a few of them too.
	task automatic load_image(input int refresh);
		int total;
		total = eff_width() * eff_height();
		if (total > 65536)
			total = 65536;
		for (int i = 0; i < total; i++)
			if (!texel_seen[i])
				put_texel(i);
		for (int i = 0; i < refresh && total > 0; i++)
			put_texel($urandom_range(0, total - 1));
	endtask

	task automatic start_span(input logic [31:0] u, input logic [31:0] v);
		in_item_t it;
		it = rand_item(CMD_START);
		it.u_start = u;
		it.v_start = v;
		send_item(it);
	endtask

	task automatic send_pixel(input logic [7:0] d);
		in_item_t it;
		it = rand_item(CMD_PIXEL);
		if (d != 8'h5A)
			{it.data_c0, it.data_c1, it.data_c2, it.data_c3} = {4{d}};
		send_item(it);
	endtask

	// start near the image so the walk crosses edges and the interior
	function automatic logic [31:0] near_start(input int side);
		return $urandom_range(0, (side + 3) << 16) - (32'd2 << 16);
	endfunction

	// ------------------------------------------------------------------ results
	// Release the output with random stalls, or a long hold when asked.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				out_stall <= 1'b1;
				long_hold--;
			end else if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				if (out_valid && !out_stall)
					hold = no_gaps ? 0 : $urandom_range(0, 5);
			end
		end
	end

	// Check each accepted result against the oldest prediction.
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				report($sformatf("unexpected result %h", out_data));
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (out_data.out_c0 !== want.out_c0)
					report($sformatf("out_c0 got %h want %h", out_data.out_c0, want.out_c0));
				if (out_data.out_c1 !== want.out_c1)
					report($sformatf("out_c1 got %h want %h", out_data.out_c1, want.out_c1));
				if (out_data.out_c2 !== want.out_c2)
					report($sformatf("out_c2 got %h want %h", out_data.out_c2, want.out_c2));
				if (out_data.out_c3 !== want.out_c3)
					report($sformatf("out_c3 got %h want %h", out_data.out_c3, want.out_c3));
			end
		end
	end

	// -------------------------------------------------------------------- tests
	// Reset values: a 1x1 image, copy of all four components, unit u step.
	task automatic test_reset_state();
		put_texel(0);
		start_span(32'h0, 32'h0);
		send_pixel(8'h5A);
		send_pixel(8'h5A);
		start_span(32'h0000_8000, 32'h0000_8000);
		send_pixel(8'h5A);
		drain();
	endtask

	// Every mode, field extremes, saturations, zero size, wrap and the unused command.
	task automatic test_directed();
		configure(MODE_RGBA, 9'd4, 9'd4, 3'd4, 32'h0000_4000, 32'h0000_6000, 24'h0);
		load_image(0);
		put_texel(5);
		start_span(32'hFFFF_8000, 32'hFFFF_C000);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_item(rand_item(CMD_NONE));
		write_reg(CFG_MODE, 32'(MODE_MASK));
		send_pixel(8'hFF);
		write_reg(CFG_MODE, 32'(MODE_TINT));
		write_reg(CFG_FILL, 32'h00FF_FFFF);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		drain();
		configure(MODE_COPY, 9'd0, 9'd3, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 24'h0);
		start_span(32'h7FFF_FFFF, 32'h8000_0000);
		send_pixel(8'h5A);
		send_pixel(8'h5A);
		drain();
		configure(MODE_COPY, 9'd511, 9'd1, 3'd7, 32'h0001_8000, 32'h0, 24'h00FF00);
		load_image(0);
		start_span(32'h00FE_8000, 32'h0);
		send_pixel(8'h5A);
		send_pixel(8'h5A);
		write_reg(CFG_COUNT, 32'd2);
		send_pixel(8'h5A);
		drain();
	endtask

	// Random configurations, each with spans of random pixels and some noise.
	task automatic test_random_spans(input int target);
		int w, h, spans, len;
		while (items_sent < target) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0: w = 0;
				1: begin w = $urandom_range(257, 511); h = 1; end
				2: begin w = 1; h = $urandom_range(250, 256); end
				3: begin w = $urandom_range(1, 2); h = $urandom_range(257, 511); end
				default: ;
			endcase
			configure(2'($urandom_range(0, 3)), 9'(w), 9'(h), 3'($urandom_range(0, 7)),
				($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 17) - (1 << 16),
				($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 17) - (1 << 16),
				24'($urandom_range(0, 24'hFFFFFF)));
			load_image($urandom_range(0, 8));
			no_gaps = ($urandom_range(0, 3) == 0);
			spans = $urandom_range(1, 4);
			for (int s = 0; s < spans; s++) begin
				if ($urandom_range(0, 9) == 0)
					start_span($urandom, $urandom);
				else
					start_span(near_start(eff_width()), near_start(eff_height()));
				len = $urandom_range(1, 20);
				for (int p = 0; p < len; p++) begin
					case ($urandom_range(0, 19))
						0: send_item(rand_item(CMD_NONE));
						1: send_item(rand_item(CMD_WRITE));
						2: send_pixel(8'h00);
						3: send_pixel(8'hFF);
						default: send_pixel(8'h5A);
					endcase
				end
			end
			no_gaps = 0;
			drain();
			phases_run++;
		end
	endtask

	// Hold the output long enough that the block backs up into its input.
	task automatic test_output_backpressure();
		configure(MODE_RGBA, 9'd8, 9'd8, 3'd4, 32'h0000_3000, 32'h0000_1800, 24'h123456);
		load_image(0);
		start_span(32'h0, 32'h0);
		long_hold = 300;
		no_gaps = 1;
		for (int p = 0; p < 40; p++)
			send_pixel(8'h5A);
		no_gaps = 0;
		drain();
	endtask

	initial begin
		for (int i = 0; i < 65536; i++) begin
			texel_mem[i]  = '0;
			texel_seen[i] = 1'b0;
		end
		pos_u = '0;
		pos_v = '0;
		mode_r = MODE_COPY;
		width_r = 9'd1;
		height_r = 9'd1;
		count_r = 3'd4;
		step_u_r = 32'd65536;
		step_v_r = '0;
		fill_r = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_directed();
		test_output_backpressure();
		test_random_spans(1900);

		$display("Ran %0d transactions over %0d random configurations;", items_sent, phases_run);
		$display("compared %0d pixels in all four blend modes.", pixels_checked);
		if (pending_pixels.size() != 0)
			report($sformatf("%0d pixels never came out", pending_pixels.size()));
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/absc_pkg.sv
hw/rtl/absc_ctrl.sv
hw/rtl/absc_dp.sv
hw/rtl/affine_bilinear_span_compositor_unit.sv
hw/rtl/absc_checker.sv
dv/affine_bilinear_span_compositor_unit_test.sv
